[hdl/length_prefixed_frame_deframer_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the length-prefixed frame deframer
// Shorthand for clocked implications checked on every rising edge of clk.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPFD_ASSERT_NOW(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPFD_ASSERT_NEXT(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

[hdl/lpfd_pkg.sv]
// ----------------------------------------------------------------------------
// lpfd_pkg
// Shared types, constants and helpers of the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package lpfd_pkg;

  localparam int BYTE_W      = 8;
  localparam int MAX_PAYLOAD = 56;
  localparam int STORE_DEPTH = 64;
  localparam int LEN_LIMIT   = (MAX_PAYLOAD < STORE_DEPTH - 8) ? MAX_PAYLOAD : STORE_DEPTH - 8;
  localparam int PTR_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int CFG_IDX_W   = 2;

  // Positions within a candidate frame, counted from the header byte.
  localparam int LEN_FIRST_POS  = 1;
  localparam int LEN_LAST_POS   = 4;
  localparam int TEXT_START_POS = 5;
  localparam int PAYLOAD_POS    = 6;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [BYTE_W:0]   wide_t;
  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER     = 2'd0,
    REG_TEXT_START = 2'd1,
    REG_TEXT_END   = 2'd2,
    REG_TRANS_END  = 2'd3
  } cfg_reg_t;

  localparam byte_t HDR_RESET = 8'h01;
  localparam byte_t STX_RESET = 8'h02;
  localparam byte_t ETX_RESET = 8'h03;
  localparam byte_t EOT_RESET = 8'h04;

  typedef enum logic [5:0] {
    PH_HUNT = 6'b000001,
    PH_LEN  = 6'b000010,
    PH_STX  = 6'b000100,
    PH_DATA = 6'b001000,
    PH_ETX  = 6'b010000,
    PH_EOT  = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    OC_ADV    = 2'd0,
    OC_DROP   = 2'd1,
    OC_REJECT = 2'd2,
    OC_DONE   = 2'd3
  } outcome_t;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_RP_READ = 5'b00010,
    ST_RP_EVAL = 5'b00100,
    ST_EM_READ = 5'b01000,
    ST_EM_SEND = 5'b10000
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic eval_rdata;
    logic rd_replay;
    logic rd_emit;
    logic send;
    logic finish;
  } cmd_t;

  typedef struct packed {
    outcome_t outcome;
    logic     more_next;
    logic     out_free;
    logic     emit_last;
  } status_t;

  // Adds an offset to a store pointer, wrapping around the circular store.
  function automatic ptr_t ptr_add(ptr_t base, cnt_t off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(STORE_DEPTH)) begin
      sum = sum - (CNT_W+1)'(STORE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

[hdl/lpfd_channels.sv]
// ----------------------------------------------------------------------------
// lpfd channels
// Valid/ready channels for incoming stream bytes and outgoing payload beats.
// ----------------------------------------------------------------------------
interface lpfd_byte_if;
  logic           valid;
  logic           ready;
  lpfd_pkg::byte_t stream_byte;

  modport source(output valid, output stream_byte, input ready);
  modport sink(input valid, input stream_byte, output ready);
endinterface

interface lpfd_result_if;
  logic           valid;
  logic           ready;
  lpfd_pkg::byte_t payload_byte;
  logic           frame_last;
  logic           frame_empty;

  modport source(output valid, output payload_byte, output frame_last,
                 output frame_empty, input ready);
  modport sink(input valid, input payload_byte, input frame_last,
               input frame_empty, output ready);
endinterface

[hdl/length_prefixed_frame_deframer.sv]
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer
// Recovers header/length/text-start/payload/text-end/trans-end frames.
// ----------------------------------------------------------------------------
// A stream byte is taken every cycle while no burst or replay runs. When the
// closing byte of a valid frame arrives, intake pauses for one store read and
// then one payload beat per cycle (one beat marked empty for a zero-length
// frame), paced by the result channel. A false start replays the buffered
// candidate bytes after its header byte through the single store read port,
// each byte read and then evaluated, with intake paused. Up to 64 bytes are
// buffered in a circular store that needs no clearing after reset.
module length_prefixed_frame_deframer (
  input  logic                           clk,
  input  logic                           rst,
  lpfd_byte_if.sink                      stream,
  lpfd_result_if.source                  payload,
  input  logic                           cfg_wr_en,
  input  logic [lpfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  lpfd_pkg::byte_t                cfg_data
);

  lpfd_pkg::cmd_t    cmd;
  lpfd_pkg::status_t status;

  lpfd_controller u_controller (
    .clk          (clk),
    .rst          (rst),
    .stream_valid (stream.valid),
    .stream_ready (stream.ready),
    .status       (status),
    .cmd          (cmd)
  );

  lpfd_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .stream_byte  (stream.stream_byte),
    .res_valid    (payload.valid),
    .res_ready    (payload.ready),
    .payload_byte (payload.payload_byte),
    .frame_last   (payload.frame_last),
    .frame_empty  (payload.frame_empty),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

[hdl/lpfd_controller.sv]
// ----------------------------------------------------------------------------
// lpfd_controller
// Sequences byte intake, replay of buffered bytes and payload bursts.
// ----------------------------------------------------------------------------
module lpfd_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              stream_valid,
  output logic              stream_ready,
  input  lpfd_pkg::status_t status,
  output lpfd_pkg::cmd_t    cmd
);

  lpfd_pkg::ctrl_state_t state;
  lpfd_pkg::ctrl_state_t state_next;

  assign stream_ready = (state == lpfd_pkg::ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      lpfd_pkg::ST_IDLE: begin
        if (stream_valid) begin
          cmd.accept = 1'b1;
          if (status.outcome == lpfd_pkg::OC_DONE) begin
            state_next = lpfd_pkg::ST_EM_READ;
          end else if (status.more_next) begin
            state_next = lpfd_pkg::ST_RP_READ;
          end
        end
      end
      lpfd_pkg::ST_RP_READ: begin
        cmd.rd_replay = 1'b1;
        state_next    = lpfd_pkg::ST_RP_EVAL;
      end
      lpfd_pkg::ST_RP_EVAL: begin
        cmd.eval_rdata = 1'b1;
        if (status.outcome == lpfd_pkg::OC_DONE) begin
          state_next = lpfd_pkg::ST_EM_READ;
        end else if (status.more_next) begin
          state_next = lpfd_pkg::ST_RP_READ;
        end else begin
          state_next = lpfd_pkg::ST_IDLE;
        end
      end
      lpfd_pkg::ST_EM_READ: begin
        cmd.rd_emit = 1'b1;
        state_next  = lpfd_pkg::ST_EM_SEND;
      end
      lpfd_pkg::ST_EM_SEND: begin
        if (status.out_free) begin
          cmd.send = 1'b1;
          if (status.emit_last) begin
            cmd.finish = 1'b1;
            state_next = status.more_next ? lpfd_pkg::ST_RP_READ : lpfd_pkg::ST_IDLE;
          end else begin
            cmd.rd_emit = 1'b1;
          end
        end
      end
      default: begin
        state_next = lpfd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpfd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hdl/lpfd_datapath.sv]
// ----------------------------------------------------------------------------
// lpfd_datapath
// Circular byte store, frame parser, configuration registers and result beat.
// ----------------------------------------------------------------------------
module lpfd_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [lpfd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  lpfd_pkg::byte_t                    cfg_data,
  input  lpfd_pkg::byte_t                    stream_byte,
  output logic                               res_valid,
  input  logic                               res_ready,
  output lpfd_pkg::byte_t                    payload_byte,
  output logic                               frame_last,
  output logic                               frame_empty,
  input  lpfd_pkg::cmd_t                     cmd,
  output lpfd_pkg::status_t                  status
);

  lpfd_pkg::byte_t header_byte;
  lpfd_pkg::byte_t text_start_byte;
  lpfd_pkg::byte_t text_end_byte;
  lpfd_pkg::byte_t trans_end_byte;

  lpfd_pkg::byte_t store [lpfd_pkg::STORE_DEPTH];
  lpfd_pkg::byte_t rdata;

  lpfd_pkg::phase_t phase;
  lpfd_pkg::phase_t phase_next;
  lpfd_pkg::byte_t  frame_length;
  lpfd_pkg::byte_t  frame_length_next;
  logic             length_over;
  logic             length_over_next;
  lpfd_pkg::ptr_t   head;
  lpfd_pkg::ptr_t   head_next;
  lpfd_pkg::cnt_t   fill;
  lpfd_pkg::cnt_t   fill_next;
  lpfd_pkg::cnt_t   idx;
  lpfd_pkg::cnt_t   idx_next;
  lpfd_pkg::cnt_t   emit_count;
  lpfd_pkg::cnt_t   emit_count_next;
  lpfd_pkg::cnt_t   removed;

  lpfd_pkg::outcome_t outcome;
  lpfd_pkg::byte_t    eval_byte;
  logic               eval;
  logic               emit_last;
  lpfd_pkg::wide_t    data_end;
  lpfd_pkg::ptr_t     wr_addr;
  lpfd_pkg::ptr_t     rd_addr;
  lpfd_pkg::cnt_t     emit_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte     <= lpfd_pkg::HDR_RESET;
      text_start_byte <= lpfd_pkg::STX_RESET;
      text_end_byte   <= lpfd_pkg::ETX_RESET;
      trans_end_byte  <= lpfd_pkg::EOT_RESET;
    end else if (cfg_wr_en) begin
      unique case (lpfd_pkg::cfg_reg_t'(cfg_index))
        lpfd_pkg::REG_HEADER:     header_byte     <= cfg_data;
        lpfd_pkg::REG_TEXT_START: text_start_byte <= cfg_data;
        lpfd_pkg::REG_TEXT_END:   text_end_byte   <= cfg_data;
        lpfd_pkg::REG_TRANS_END:  trans_end_byte  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eval      = cmd.accept | cmd.eval_rdata;
  assign eval_byte = cmd.accept ? stream_byte : rdata;
  assign data_end  = lpfd_pkg::wide_t'(frame_length)
                   + lpfd_pkg::wide_t'(lpfd_pkg::TEXT_START_POS);

  always_comb begin
    outcome           = lpfd_pkg::OC_ADV;
    phase_next        = phase;
    frame_length_next = frame_length;
    length_over_next  = length_over;
    unique case (phase)
      lpfd_pkg::PH_HUNT: begin
        if (eval_byte == header_byte) begin
          phase_next        = lpfd_pkg::PH_LEN;
          frame_length_next = '0;
          length_over_next  = 1'b0;
        end else begin
          outcome = lpfd_pkg::OC_DROP;
        end
      end
      lpfd_pkg::PH_LEN: begin
        if (idx == lpfd_pkg::cnt_t'(lpfd_pkg::LEN_FIRST_POS)) begin
          frame_length_next = eval_byte;
        end else if (eval_byte != '0) begin
          length_over_next = 1'b1;
        end
        if (idx >= lpfd_pkg::cnt_t'(lpfd_pkg::LEN_LAST_POS)) begin
          phase_next = lpfd_pkg::PH_STX;
        end
      end
      lpfd_pkg::PH_STX: begin
        if (eval_byte != text_start_byte || length_over
            || frame_length > lpfd_pkg::byte_t'(lpfd_pkg::LEN_LIMIT)) begin
          outcome = lpfd_pkg::OC_REJECT;
        end else if (frame_length == '0) begin
          phase_next = lpfd_pkg::PH_ETX;
        end else begin
          phase_next = lpfd_pkg::PH_DATA;
        end
      end
      lpfd_pkg::PH_DATA: begin
        if (lpfd_pkg::wide_t'(idx) >= data_end) begin
          phase_next = lpfd_pkg::PH_ETX;
        end
      end
      lpfd_pkg::PH_ETX: begin
        if (eval_byte != text_end_byte) begin
          outcome = lpfd_pkg::OC_REJECT;
        end else begin
          phase_next = lpfd_pkg::PH_EOT;
        end
      end
      lpfd_pkg::PH_EOT: begin
        if (eval_byte != trans_end_byte) begin
          outcome = lpfd_pkg::OC_REJECT;
        end else begin
          outcome = lpfd_pkg::OC_DONE;
        end
      end
      default: begin
        outcome = lpfd_pkg::OC_REJECT;
      end
    endcase
  end

  assign emit_last = (frame_length == '0)
                   || (lpfd_pkg::byte_t'(emit_count) + lpfd_pkg::byte_t'(1) == frame_length);

  always_comb begin
    head_next       = head;
    idx_next        = idx;
    emit_count_next = emit_count;
    removed         = '0;
    if (eval) begin
      unique case (outcome) inside
        lpfd_pkg::OC_ADV: idx_next = idx + lpfd_pkg::cnt_t'(1);
        lpfd_pkg::OC_DROP,
        lpfd_pkg::OC_REJECT: begin
          head_next = lpfd_pkg::ptr_add(head, lpfd_pkg::cnt_t'(1));
          idx_next  = '0;
          removed   = lpfd_pkg::cnt_t'(1);
        end
        lpfd_pkg::OC_DONE: ;
        default: ;
      endcase
    end
    if (cmd.finish) begin
      head_next       = lpfd_pkg::ptr_add(head, idx + lpfd_pkg::cnt_t'(1));
      idx_next        = '0;
      removed         = idx + lpfd_pkg::cnt_t'(1);
      emit_count_next = '0;
    end else if (cmd.send) begin
      emit_count_next = emit_count + lpfd_pkg::cnt_t'(1);
    end
    fill_next = fill + lpfd_pkg::cnt_t'(cmd.accept) - removed;
  end

  assign status.outcome   = outcome;
  assign status.more_next = (idx_next < fill_next);
  assign status.out_free  = !res_valid || res_ready;
  assign status.emit_last = emit_last;

  assign emit_off = lpfd_pkg::cnt_t'(lpfd_pkg::PAYLOAD_POS) + emit_count
                  + lpfd_pkg::cnt_t'(cmd.send);
  assign wr_addr  = lpfd_pkg::ptr_add(head, fill);
  assign rd_addr  = cmd.rd_emit ? lpfd_pkg::ptr_add(head, emit_off)
                                : lpfd_pkg::ptr_add(head, idx);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      store[wr_addr] <= stream_byte;
    end
    if (cmd.rd_replay || cmd.rd_emit) begin
      rdata <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= lpfd_pkg::PH_HUNT;
      frame_length <= '0;
      length_over  <= 1'b0;
      head         <= '0;
      fill         <= '0;
      idx          <= '0;
      emit_count   <= '0;
    end else begin
      head       <= head_next;
      fill       <= fill_next;
      idx        <= idx_next;
      emit_count <= emit_count_next;
      if (eval) begin
        frame_length <= frame_length_next;
        length_over  <= length_over_next;
        if (outcome == lpfd_pkg::OC_REJECT) begin
          phase <= lpfd_pkg::PH_HUNT;
        end else begin
          phase <= phase_next;
        end
      end else if (cmd.finish) begin
        phase <= lpfd_pkg::PH_HUNT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.send) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.send) begin
      payload_byte <= (frame_length == '0) ? '0 : rdata;
      frame_last   <= emit_last;
      frame_empty  <= (frame_length == '0);
    end
  end

endmodule

[hdl/lpfd_checker.sv]
// ----------------------------------------------------------------------------
// lpfd_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "length_prefixed_frame_deframer_macros.svh"

module lpfd_checker (
  input logic            clk,
  input logic            rst,
  input logic            stream_ready,
  input logic            payload_valid,
  input logic            payload_ready,
  input lpfd_pkg::byte_t payload_byte,
  input logic            frame_last,
  input logic            frame_empty
);

  `LPFD_ASSERT_NEXT(a_beat_held, payload_valid && !payload_ready, payload_valid, "Result beat dropped while stalled.")
  `LPFD_ASSERT_NEXT(a_beat_stable, payload_valid && !payload_ready, $stable(payload_byte) && $stable(frame_last) && $stable(frame_empty), "Result beat changed while stalled.")
  `LPFD_ASSERT_NOW(a_empty_beat, payload_valid && frame_empty, frame_last && payload_byte == '0, "Empty frame beat is not a lone zero beat.")
  `LPFD_ASSERT_NOW(a_burst_blocks_input, payload_valid && !frame_last, !stream_ready, "Stream byte taken in the middle of a payload burst.")

endmodule

bind length_prefixed_frame_deframer lpfd_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .stream_ready  (stream.ready),
  .payload_valid (payload.valid),
  .payload_ready (payload.ready),
  .payload_byte  (payload.payload_byte),
  .frame_last    (payload.frame_last),
  .frame_empty   (payload.frame_empty)
);

[sim/deframer_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Deframer checker
// Watches the stream and payload channels and the register port of the
// deframer. It keeps its own copy of the frame parser, works out the payload
// beats each accepted stream byte should release, and compares every
// delivered beat with the oldest one still awaited.
// ----------------------------------------------------------------------------
module deframer_checker
  import lpfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  lpfd_byte_if                  stream,
  lpfd_result_if                payload,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  byte_t                 cfg_data,
  output int                    fail_count,
  output int                    beats_pending,
  output int                    frames_checked,
  output logic                  parser_clear
);

  typedef struct {
    byte_t data;
    logic  last;
    logic  empty;
  } payload_beat_t;

  payload_beat_t awaited_beats[$];

  byte_t       hdr_code;
  byte_t       stx_code;
  byte_t       etx_code;
  byte_t       eot_code;
  phase_t      state;
  logic [31:0] length_field;
  byte_t       store [STORE_DEPTH];
  int unsigned fill;
  int unsigned replay_at;

  task automatic reset_parser();
    hdr_code = HDR_RESET;
    stx_code = STX_RESET;
    etx_code = ETX_RESET;
    eot_code = EOT_RESET;
    state = PH_HUNT;
    length_field = '0;
    fill = 0;
    replay_at = 0;
    awaited_beats.delete();
  endtask

  task automatic take_stream_byte(input byte_t value);
    int unsigned pos;
    int unsigned base;
    int unsigned idx;
    int unsigned k;
    byte_t       b;
    outcome_t    step;
    if (fill >= STORE_DEPTH) begin
      fill = 0;
    end
    store[fill] = value;
    fill++;
    pos = (replay_at < fill) ? replay_at : fill - 1;
    base = 0;
    while (pos < fill) begin
      b = store[pos];
      idx = pos - base;
      step = OC_ADV;
      case (state)
        PH_HUNT: begin
          if (b == hdr_code) begin
            state = PH_LEN;
            length_field = '0;
          end else begin
            step = OC_DROP;
          end
        end
        PH_LEN: begin
          length_field |= 32'(b) << (8 * ((idx - 1) % 4));
          if (idx >= LEN_LAST_POS) begin
            state = PH_STX;
          end
        end
        PH_STX: begin
          if (b != stx_code || length_field > LEN_LIMIT) begin
            step = OC_REJECT;
          end else begin
            state = (length_field == 0) ? PH_ETX : PH_DATA;
          end
        end
        PH_DATA: begin
          if (idx >= TEXT_START_POS + length_field) begin
            state = PH_ETX;
          end
        end
        PH_ETX: begin
          if (b != etx_code) begin
            step = OC_REJECT;
          end else begin
            state = PH_EOT;
          end
        end
        default: begin
          if (b != eot_code) begin
            step = OC_REJECT;
          end else begin
            step = OC_DONE;
            if (length_field == 0) begin
              awaited_beats.push_back('{data: '0, last: 1'b1, empty: 1'b1});
            end else begin
              for (k = 0; k < length_field; k++) begin
                awaited_beats.push_back('{data: store[base + PAYLOAD_POS + k],
                                         last: (k + 1 == length_field),
                                         empty: 1'b0});
              end
            end
          end
        end
      endcase
      case (step)
        OC_ADV: begin
          pos++;
        end
        OC_REJECT: begin
          state = PH_HUNT;
          pos = base + 1;
          base = pos;
        end
        default: begin
          state = PH_HUNT;
          pos++;
          base = pos;
        end
      endcase
    end
    if (base > 0) begin
      for (k = 0; k < fill - base; k++) begin
        store[k] = store[k + base];
      end
      fill -= base;
    end
    replay_at = fill;
  endtask

  task automatic check_beat();
    payload_beat_t want;
    if (awaited_beats.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected payload beat, expected none, actual %h last=%b empty=%b",
               $time, payload.payload_byte, payload.frame_last, payload.frame_empty);
    end else begin
      want = awaited_beats.pop_front();
      if (payload.payload_byte !== want.data) begin
        fail_count++;
        $display("%0t: payload_byte mismatch, expected %h, actual %h",
                 $time, want.data, payload.payload_byte);
      end
      if (payload.frame_last !== want.last) begin
        fail_count++;
        $display("%0t: frame_last mismatch, expected %b, actual %b",
                 $time, want.last, payload.frame_last);
      end
      if (payload.frame_empty !== want.empty) begin
        fail_count++;
        $display("%0t: frame_empty mismatch, expected %b, actual %b",
                 $time, want.empty, payload.frame_empty);
      end
      if (want.last) begin
        frames_checked++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_parser();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_HEADER:     hdr_code = cfg_data;
          REG_TEXT_START: stx_code = cfg_data;
          REG_TEXT_END:   etx_code = cfg_data;
          default:        eot_code = cfg_data;
        endcase
      end
      if (stream.valid && stream.ready) begin
        take_stream_byte(stream.stream_byte);
      end
      if (payload.valid && payload.ready) begin
        check_beat();
      end
    end
    beats_pending = awaited_beats.size();
    parser_clear = (state == PH_HUNT) && (fill == 0);
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Length-prefixed frame deframer testbench
// Drives byte streams of well-formed, corrupted and noisy frames through the
// deframer under several delimiter settings, with bursty input and a stalling
// payload receiver. A checker beside the block predicts and compares beats.
// ----------------------------------------------------------------------------
module testbench;
  import lpfd_pkg::*;

  localparam int HOLD_OFF = 4 * STORE_DEPTH + 64;

  typedef enum int {
    FLAW_NONE,
    FLAW_TEXT_START,
    FLAW_LENGTH,
    FLAW_TEXT_END,
    FLAW_TRANS_END
  } flaw_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cfg_wr_en;
  cfg_reg_t cfg_index;
  byte_t    cfg_data;

  int fail_count;
  int beats_pending;
  int frames_checked;
  logic parser_clear;

  byte_t       cur_hdr = HDR_RESET;
  byte_t       cur_stx = STX_RESET;
  byte_t       cur_etx = ETX_RESET;
  byte_t       cur_eot = EOT_RESET;
  int unsigned sent_count = 0;
  int unsigned settings_used = 1;
  int unsigned burst_left = 0;
  bit          calm = 1'b0;
  int unsigned rx_left = 0;
  logic        rx_open = 1'b0;

  lpfd_byte_if   stream_ch ();
  lpfd_result_if result_ch ();

  length_prefixed_frame_deframer uut (
    .clk       (clk),
    .rst       (rst),
    .stream    (stream_ch),
    .payload   (result_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  deframer_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .stream         (stream_ch),
    .payload        (result_ch),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .beats_pending  (beats_pending),
    .frames_checked (frames_checked),
    .parser_clear   (parser_clear)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("FAIL length_prefixed_frame_deframer");
    $finish;
  end

  always @(negedge clk) begin
    if (calm) begin
      result_ch.ready <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_open = !rx_open;
        rx_left = rx_open ? $urandom_range(1, 20) : $urandom_range(1, 8);
      end
      rx_left--;
      result_ch.ready <= rx_open;
    end
  end

  task automatic send_byte(input byte_t value);
    if (burst_left == 0) begin
      if (calm) begin
        burst_left = 1000;
      end else begin
        burst_left = $urandom_range(1, 12);
        stream_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    stream_ch.valid <= 1'b1;
    stream_ch.stream_byte <= value;
    @(posedge clk);
    while (!stream_ch.ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    burst_left--;
    sent_count++;
  endtask

  task automatic drain();
    stream_ch.valid <= 1'b0;
    @(negedge clk);
    while (beats_pending != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input byte_t value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_HEADER:     cur_hdr = value;
      REG_TEXT_START: cur_stx = value;
      REG_TEXT_END:   cur_etx = value;
      default:        cur_eot = value;
    endcase
  endtask

  // Filler bytes that can never open a frame push any partial candidate
  // through to a verdict, so the parser is empty before the registers change.
  task automatic configure(input byte_t hdr, input byte_t stx, input byte_t etx,
                           input byte_t eot);
    while (!parser_clear) begin
      send_byte(~cur_hdr);
    end
    drain();
    repeat (HOLD_OFF) @(negedge clk);
    write_reg(REG_HEADER, hdr);
    write_reg(REG_TEXT_START, stx);
    write_reg(REG_TEXT_END, etx);
    write_reg(REG_TRANS_END, eot);
    settings_used++;
  endtask

  function automatic byte_t other_than(input byte_t value);
    return value ^ byte_t'($urandom_range(1, 255));
  endfunction

  task automatic send_frame(input int unsigned len, input flaw_t flaw);
    logic [31:0] len_field;
    int unsigned i;
    len_field = len;
    if (flaw == FLAW_LENGTH) begin
      len_field = $urandom_range(0, 1) ? $urandom_range(LEN_LIMIT + 1, 255) : $urandom;
    end
    send_byte(cur_hdr);
    for (i = 0; i < 4; i++) begin
      send_byte(len_field[8*i +: 8]);
    end
    send_byte((flaw == FLAW_TEXT_START) ? other_than(cur_stx) : cur_stx);
    for (i = 0; i < len; i++) begin
      send_byte(byte_t'($urandom));
    end
    send_byte((flaw == FLAW_TEXT_END) ? other_than(cur_etx) : cur_etx);
    send_byte((flaw == FLAW_TRANS_END) ? other_than(cur_eot) : cur_eot);
  endtask

  task automatic random_item();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, LEN_LIMIT) : $urandom_range(0, 6);
    if ($urandom_range(0, 25) == 0) begin
      len = LEN_LIMIT;
    end
    if (pick < 65) begin
      send_frame(len, FLAW_NONE);
    end else if (pick < 85) begin
      send_frame(len, flaw_t'($urandom_range(FLAW_TEXT_START, FLAW_TRANS_END)));
    end else begin
      repeat ($urandom_range(1, 5)) begin
        send_byte(($urandom_range(0, 3) == 0) ? cur_hdr : byte_t'($urandom));
      end
    end
  endtask

  task automatic random_phase(input int unsigned count, input bit pause_midway);
    int unsigned stop_at;
    int unsigned pause_at;
    stop_at = sent_count + count;
    pause_at = sent_count + count / 2;
    while (sent_count < stop_at) begin
      random_item();
      if (pause_midway && sent_count >= pause_at) begin
        drain();
        pause_midway = 1'b0;
      end
    end
  endtask

  // A one-byte frame, a false start whose replay holds an empty frame, a
  // length just over the limit and a bad closing byte.
  task automatic opening_frames();
    byte_t seq[$];
    seq = '{HDR_RESET, 8'h01, 8'h00, 8'h00, 8'h00, STX_RESET, 8'hFF, ETX_RESET, EOT_RESET,
            HDR_RESET, HDR_RESET, 8'h00, 8'h00, 8'h00, 8'h00, STX_RESET, ETX_RESET,
            EOT_RESET,
            HDR_RESET, byte_t'(LEN_LIMIT + 1), 8'h00, 8'h00, 8'h00, STX_RESET,
            HDR_RESET, 8'h00, 8'h00, 8'h00, 8'h00, STX_RESET, ETX_RESET, 8'hFF};
    foreach (seq[i]) begin
      send_byte(seq[i]);
    end
  endtask

  initial begin
    stream_ch.valid = 1'b0;
    stream_ch.stream_byte = '0;
    result_ch.ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_HEADER;
    cfg_data = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    opening_frames();
    random_phase(85, 1'b1);

    configure(8'h00, 8'hFF, 8'h00, 8'hFF);
    random_phase(85, 1'b0);

    configure(8'hFF, 8'h00, 8'hFF, 8'h00);
    calm = 1'b1;
    burst_left = 0;
    random_phase(85, 1'b0);
    calm = 1'b0;
    burst_left = 0;

    configure(byte_t'($urandom), byte_t'($urandom), byte_t'($urandom), byte_t'($urandom));
    random_phase(85, 1'b0);

    configure(8'h55, 8'h55, 8'h55, 8'h55);
    random_phase(60, 1'b0);

    configure(HDR_RESET, STX_RESET, ETX_RESET, EOT_RESET);
    random_phase(40, 1'b0);

    drain();
    repeat (HOLD_OFF) @(negedge clk);

    $display("Sent %0d stream bytes under %0d delimiter settings; %0d frame bursts checked.",
             sent_count, settings_used, frames_checked);
    if (beats_pending != 0) begin
      $display("%0t: %0d expected payload beats never arrived", $time, beats_pending);
    end
    if (fail_count == 0 && beats_pending == 0) begin
      $display("PASS length_prefixed_frame_deframer");
    end else begin
      $display("FAIL length_prefixed_frame_deframer");
    end
    $finish;
  end

endmodule
